[sv/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// Constants, types and helpers shared by the depth-first path finder.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // Graph size.
  localparam int NODES      = 16;
  localparam int MAX_DEGREE = 4;

  // Node fields on the ports are four bits wide, so no node above 15 exists.
  localparam int NODE_W     = 4;
  localparam int NODE_LIMIT = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);

  // Derived widths.
  localparam int NIDX_W      = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
  localparam int CNT_W       = $clog2(MAX_DEGREE + 1);
  localparam int DEP_W       = $clog2(NODE_LIMIT + 1);
  localparam int STORE_DEPTH = NODE_LIMIT * MAX_DEGREE;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Request kinds carried in tuser.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  // Edge-store result codes.
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_FIND,
    S_CHECK,
    S_POP,
    S_EDGE,
    S_OUT_ISSUE,
    S_OUT_STACK,
    S_OUT_TOP,
    S_EMIT_TARGET,
    S_EMIT_SINGLE
  } state_t;

  // One saved level of the walk: the node and the next successor to try.
  typedef struct packed {
    logic [NIDX_W-1:0] node;
    logic [CNT_W-1:0]  next;
  } stack_entry_t;

  function automatic logic in_range(logic [NODE_W-1:0] node);
    in_range = ({1'b0, node} < (NODE_W + 1)'(NODE_LIMIT));
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(logic [NIDX_W-1:0] node,
                                                     logic [CNT_W-1:0] slot);
    store_addr = STORE_AW'(int'(node) * MAX_DEGREE + int'(slot));
  endfunction

endpackage

[sv/dfs_path_finder.sv]
// ----------------------------------------------------------------------------
// dfs_path_finder
// Directed graph store with a depth-first path search over insertion-ordered
// successor lists, driven by a small sequencer around two block memories.
// ----------------------------------------------------------------------------
// A beat on the slave side either appends an edge (tuser 0) or asks for a
// path (tuser 1); tdata carries the source or start node in bits 3:0 and the
// destination or target node in bits 7:4. An edge beat gives one result beat
// on the master side, with tuser bit 1 set when the source list was full or
// a node was out of range. A search beat walks the graph one step at a time:
// each successor tried takes one read of the edge memory, each backtrack one
// read of the stack memory, and each node of the found path is then sent out
// in turn, waiting on any stall on the master side. The slave side is ready
// only while the sequencer is idle. Results leave through an output register,
// so the next request may be taken while the last result beat still waits.
// The edge and stack memories need no clearing after reset.
module dfs_path_finder
  import dfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] from_node, [7:4] to_node
  input  logic [0:0] s_tuser,   // [0] req_type
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] path_node, [7:4] zero
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] found, [1] status
);

  state_t state, state_next;

  // Latched request.
  logic [NODE_W-1:0] node_a, node_b;

  // Walk registers: the top level lives in registers, lower levels in memory.
  logic [NIDX_W-1:0] top_node, top_node_next;
  logic [CNT_W-1:0]  top_next, top_next_next;
  logic [DEP_W-1:0]  depth, depth_next;
  logic [NIDX_W-1:0] out_idx, out_idx_next;
  logic              st_flag, st_flag_next;

  logic [NODE_LIMIT-1:0] visited;
  logic [CNT_W-1:0]      count [NODE_LIMIT];

  logic                  vis_clear, vis_set;
  logic [NIDX_W-1:0]     vis_idx;
  logic [NODE_LIMIT-1:0] vis_onehot;
  logic                  cnt_inc;

  // Edge memory.
  logic [NIDX_W-1:0]   nb_mem [STORE_DEPTH];
  logic [NIDX_W-1:0]   nb_rdata;
  logic                nb_we, nb_re;
  logic [STORE_AW-1:0] nb_waddr, nb_raddr;

  // Walk stack memory.
  stack_entry_t      stk_mem [NODE_LIMIT];
  stack_entry_t      stk_rdata, stk_wdata;
  logic              stk_we, stk_re;
  logic [NIDX_W-1:0] stk_waddr, stk_raddr;

  // Output register.
  logic              out_load;
  logic [NODE_W-1:0] out_node, out_node_next;
  logic              out_found, out_found_next;
  logic              out_last, out_last_next;
  logic              out_status, out_status_next;
  logic              slot_free;

  logic [NIDX_W-1:0] a_idx, b_idx;
  logic              req_ok;

  assign a_idx      = node_a[NIDX_W-1:0];
  assign b_idx      = node_b[NIDX_W-1:0];
  assign req_ok     = in_range(node_a) && in_range(node_b);
  assign slot_free  = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE) && !rst;
  assign vis_onehot = NODE_LIMIT'(1) << vis_idx;

  assign m_tdata = {{(8 - NODE_W){1'b0}}, out_node};
  assign m_tlast = out_last;
  assign m_tuser = {out_status, out_found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    top_node_next   = top_node;
    top_next_next   = top_next;
    depth_next      = depth;
    out_idx_next    = out_idx;
    st_flag_next    = st_flag;
    vis_clear       = 1'b0;
    vis_set         = 1'b0;
    vis_idx         = a_idx;
    cnt_inc         = 1'b0;
    nb_we           = 1'b0;
    nb_re           = 1'b0;
    nb_waddr        = store_addr(a_idx, count[a_idx]);
    nb_raddr        = store_addr(top_node, top_next);
    stk_we          = 1'b0;
    stk_re          = 1'b0;
    stk_waddr       = NIDX_W'(depth - 1'b1);
    stk_wdata       = '{node: top_node, next: top_next};
    stk_raddr       = out_idx;
    out_load        = 1'b0;
    out_node_next   = '0;
    out_found_next  = 1'b0;
    out_last_next   = 1'b0;
    out_status_next = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == REQ_FIND) ? S_FIND : S_ADD;
        end
      end

      S_ADD: begin
        if (req_ok && (count[a_idx] < CNT_W'(MAX_DEGREE))) begin
          nb_we        = 1'b1;
          cnt_inc      = 1'b1;
          st_flag_next = ST_OK;
        end else begin
          st_flag_next = ST_FULL;
        end
        state_next = S_EMIT_SINGLE;
      end

      S_FIND: begin
        vis_clear    = 1'b1;
        st_flag_next = ST_OK;
        if (!req_ok) begin
          state_next = S_EMIT_SINGLE;
        end else if (node_a == node_b) begin
          state_next = S_EMIT_TARGET;
        end else begin
          vis_set       = 1'b1;
          vis_idx       = a_idx;
          top_node_next = a_idx;
          top_next_next = '0;
          depth_next    = DEP_W'(1);
          state_next    = S_CHECK;
        end
      end

      S_CHECK: begin
        if (top_next >= count[top_node]) begin
          if (depth == DEP_W'(1)) begin
            st_flag_next = ST_OK;
            state_next   = S_EMIT_SINGLE;
          end else begin
            // Backtrack: the level below the top comes back from memory.
            depth_next = depth - 1'b1;
            stk_re     = 1'b1;
            stk_raddr  = NIDX_W'(depth - DEP_W'(2));
            state_next = S_POP;
          end
        end else begin
          nb_re         = 1'b1;
          top_next_next = top_next + 1'b1;
          state_next    = S_EDGE;
        end
      end

      S_POP: begin
        top_node_next = stk_rdata.node;
        top_next_next = stk_rdata.next;
        state_next    = S_CHECK;
      end

      S_EDGE: begin
        if (nb_rdata == b_idx) begin
          out_idx_next = '0;
          state_next   = S_OUT_ISSUE;
        end else if (!visited[nb_rdata]) begin
          vis_set       = 1'b1;
          vis_idx       = nb_rdata;
          stk_we        = 1'b1;
          top_node_next = nb_rdata;
          top_next_next = '0;
          depth_next    = depth + 1'b1;
          state_next    = S_CHECK;
        end else begin
          state_next = S_CHECK;
        end
      end

      S_OUT_ISSUE: begin
        if (DEP_W'(out_idx) == depth - 1'b1) begin
          state_next = S_OUT_TOP;
        end else begin
          stk_re     = 1'b1;
          state_next = S_OUT_STACK;
        end
      end

      S_OUT_STACK: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_node_next  = NODE_W'(stk_rdata.node);
          out_found_next = 1'b1;
          out_idx_next   = out_idx + 1'b1;
          state_next     = S_OUT_ISSUE;
        end
      end

      S_OUT_TOP: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_node_next  = NODE_W'(top_node);
          out_found_next = 1'b1;
          state_next     = S_EMIT_TARGET;
        end
      end

      S_EMIT_TARGET: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_node_next  = node_b;
          out_found_next = 1'b1;
          out_last_next  = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_EMIT_SINGLE: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_last_next   = 1'b1;
          out_status_next = st_flag;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Request latch and walk registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      node_a <= s_tdata[3:0];
      node_b <= s_tdata[7:4];
    end
    top_node <= top_node_next;
    top_next <= top_next_next;
    depth    <= depth_next;
    out_idx  <= out_idx_next;
    st_flag  <= st_flag_next;
  end

  // Visited marks and list lengths are cleared by reset. A search start
  // clears the marks and sets the start node's mark in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      for (int i = 0; i < NODE_LIMIT; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (vis_clear || vis_set) begin
        visited <= (vis_clear ? '0 : visited) | (vis_set ? vis_onehot : '0);
      end
      if (cnt_inc) begin
        count[a_idx] <= count[a_idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= b_idx;
    end
    if (nb_re) begin
      nb_rdata <= nb_mem[nb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node   <= out_node_next;
      out_found  <= out_found_next;
      out_last   <= out_last_next;
      out_status <= out_status_next;
    end
  end

endmodule

[sim/dfs_path_finder_tb.sv]
// ----------------------------------------------------------------------------
// dfs_path_finder_tb
// Self-checking bench for the depth-first path finder. Edge and search beats
// are sent on the slave side with random gaps while the master side stalls
// at random. A software copy of the graph works out every result beat, and
// each beat that leaves the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module dfs_path_finder_tb;
  import dfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PATH_MAX    = 16;

  typedef struct {
    logic [3:0] node;
    logic       found;
    logic       last;
    logic       status;
  } path_beat_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [3:0] from_node, [7:4] to_node
  logic [0:0] s_tuser;   // [0] req_type
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [3:0] path_node, [7:4] zero
  logic       m_tlast;
  logic [1:0] m_tuser;   // [0] found, [1] status

  // Software copy of the graph: successor lists in insertion order.
  logic [3:0] succ_list [NODE_LIMIT][MAX_DEGREE];
  int         succ_count [NODE_LIMIT];

  path_beat_t pending_beats [$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         gapless = 1'b0;

  dfs_path_finder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void push_beat(logic [3:0] node, logic found, logic last,
                                    logic status);
    path_beat_t b;
    b.node   = node;
    b.found  = found;
    b.last   = last;
    b.status = status;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // Works out the result beats of one accepted request and updates the graph.
  function automatic void predict_path(logic req, logic [3:0] src, logic [3:0] dst);
    bit         seen [NODE_LIMIT];
    logic [3:0] walk_node [NODE_LIMIT];
    int         walk_next [NODE_LIMIT];
    int         depth;
    int         top;
    logic [3:0] n;
    logic [3:0] w;
    bit         hit;
    bit         in_graph;
    logic       st;

    in_graph = (int'(src) < NODE_LIMIT) && (int'(dst) < NODE_LIMIT);
    if (req == REQ_ADD) begin
      st = ST_OK;
      if (!in_graph || succ_count[src] >= MAX_DEGREE) begin
        st = ST_FULL;
      end else begin
        succ_list[src][succ_count[src]] = dst;
        succ_count[src]++;
      end
      push_beat(4'd0, 1'b0, 1'b1, st);
      return;
    end

    if (!in_graph) begin
      push_beat(4'd0, 1'b0, 1'b1, ST_OK);
      return;
    end

    foreach (seen[i]) seen[i] = 1'b0;
    hit   = 1'b0;
    depth = 0;
    if (src == dst) begin
      hit = 1'b1;
    end else begin
      seen[src]    = 1'b1;
      walk_node[0] = src;
      walk_next[0] = 0;
      depth        = 1;
      while (depth > 0 && !hit) begin
        top = depth - 1;
        n   = walk_node[top];
        if (walk_next[top] >= succ_count[n]) begin
          depth--;
        end else begin
          w = succ_list[n][walk_next[top]];
          walk_next[top]++;
          if (w == dst) begin
            hit = 1'b1;
          end else if (int'(w) < NODE_LIMIT && !seen[w] && depth < NODES) begin
            seen[w]          = 1'b1;
            walk_node[depth] = w;
            walk_next[depth] = 0;
            depth++;
          end
        end
      end
    end

    if (!hit) begin
      push_beat(4'd0, 1'b0, 1'b1, ST_OK);
      return;
    end
    if (depth > PATH_MAX - 1) depth = PATH_MAX - 1;
    for (int i = 0; i < depth; i++) push_beat(walk_node[i], 1'b1, 1'b0, ST_OK);
    push_beat(dst, 1'b1, 1'b1, ST_OK);
  endfunction

  task automatic flag_error(string msg);
    if (error_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Result checker: every accepted beat against the oldest prediction.
  always @(posedge clk) begin : result_check
    path_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        flag_error($sformatf("unexpected beat tdata=%h tlast=%b tuser=%b",
                             m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_beats.pop_front();
        if (m_tdata !== {4'd0, want.node} || m_tlast !== want.last ||
            m_tuser[0] !== want.found || m_tuser[1] !== want.status) begin
          flag_error($sformatf(
            {"node exp %0d got %0d (tdata %h), found exp %b got %b, ",
             "last exp %b got %b, status exp %b got %b"},
            want.node, m_tdata[3:0], m_tdata, want.found, m_tuser[0],
            want.last, m_tlast, want.status, m_tuser[1]));
        end
      end
    end
  end

  // Master side: a fresh stall is drawn for every result beat.
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = gapless ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Sends one request beat after a random gap and returns at its handshake.
  task automatic send_item(logic req, logic [3:0] src, logic [3:0] dst);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {dst, src};
    do @(posedge clk); while (!s_tready);
    predict_path(req, src, dst);
  endtask

  // Holds the slave side off until every predicted beat has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_edge_cases();
    send_item(REQ_FIND, 4'd0, 4'd15);   // empty graph: not found
    send_item(REQ_FIND, 4'd15, 4'd15);  // start equals target
    send_item(REQ_FIND, 4'd0, 4'd0);
    send_item(REQ_ADD, 4'd0, 4'd1);
    send_item(REQ_ADD, 4'd1, 4'd2);
    send_item(REQ_ADD, 4'd2, 4'd15);
    send_item(REQ_FIND, 4'd0, 4'd15);
    send_item(REQ_FIND, 4'd15, 4'd0);
    send_item(REQ_ADD, 4'd3, 4'd3);     // self-loop, then a duplicate of it
    send_item(REQ_ADD, 4'd3, 4'd3);
    send_item(REQ_FIND, 4'd3, 4'd0);
    send_item(REQ_ADD, 4'd4, 4'd5);
    send_item(REQ_ADD, 4'd4, 4'd6);
    send_item(REQ_ADD, 4'd4, 4'd7);
    send_item(REQ_ADD, 4'd4, 4'd8);
    send_item(REQ_ADD, 4'd4, 4'd9);     // list already full
    send_item(REQ_ADD, 4'd8, 4'd14);
    send_item(REQ_ADD, 4'd6, 4'd4);     // loops back to a visited node
    send_item(REQ_FIND, 4'd4, 4'd14);   // backtracks over dead ends
    send_item(REQ_ADD, 4'd15, 4'd0);
    send_item(REQ_FIND, 4'd2, 4'd1);
    send_item(REQ_FIND, 4'd14, 4'd4);
    drain_results();
  endtask

  // A chain through every node in random order gives the longest paths.
  task automatic test_long_chain();
    logic [3:0] order [NODE_LIMIT];
    logic [3:0] tmp;
    int         j;
    foreach (order[i]) order[i] = 4'(i);
    for (int i = NODE_LIMIT - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NODE_LIMIT - 1; i++) send_item(REQ_ADD, order[i], order[i + 1]);
    send_item(REQ_FIND, order[0], order[NODE_LIMIT - 1]);
    for (int i = 0; i < 20; i++)
      send_item(REQ_FIND, order[$urandom_range(0, 3)],
                order[$urandom_range(NODE_LIMIT - 4, NODE_LIMIT - 1)]);
    drain_results();
  endtask

  task automatic test_back_to_back();
    gapless = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(($urandom_range(0, 3) == 0) ? REQ_ADD : REQ_FIND,
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    drain_results();
    gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [3:0] src;
    for (int i = 0; i < 350; i++) begin
      src = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 3)
        send_item(REQ_ADD, src, 4'($urandom_range(0, 15)));
      else if ($urandom_range(0, 6) == 0)
        send_item(REQ_FIND, src, src);
      else
        send_item(REQ_FIND, src, 4'($urandom_range(0, 15)));
      if (i == 175) drain_results();
    end
    drain_results();
  endtask

  initial begin
    foreach (succ_count[i]) succ_count[i] = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_ADD;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_long_chain();
    test_back_to_back();
    test_random_traffic();

    // Any late or extra beat would be caught here.
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
